// File: rtl/core/rpce_pkg.sv
// Shared widths, request kinds and constants for the RTC periodic and compare event unit.
`default_nettype none

package rpce_pkg;

  localparam int COUNT_W  = 32;  // Tick counter and compare target width.
  localparam int KIND_W   = 2;
  localparam int SLOT_W   = 3;
  localparam int MASK_W   = 8;   // Width of the fire and armed bit fields.
  localparam int SUB_BITS = 7;   // Low count bits that pick the periodic rate.
  localparam int CFG_DW   = 32;
  localparam int CFG_AW   = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 2'd0,
    KIND_ARM    = 2'd1,
    KIND_DISARM = 2'd2
  } kind_t;

  localparam logic [CFG_AW-1:0] ADDR_PERIODIC_ENABLE = 2'd0;

endpackage

`default_nettype wire

// File: rtl/core/rpce_cmd_if.sv
// Request channel carrying ticks and compare slot arm and disarm requests.
`default_nettype none

interface rpce_cmd_if;
  logic                             valid;
  logic                             ready;
  logic [rpce_pkg::KIND_W-1:0]      kind;
  logic [rpce_pkg::SLOT_W-1:0]      slot;
  logic [rpce_pkg::COUNT_W-1:0]     compare_value;

  modport source (output valid, kind, slot, compare_value, input ready);
  modport sink   (input valid, kind, slot, compare_value, output ready);
endinterface

`default_nettype wire

// File: rtl/core/rpce_evt_if.sv
// Result channel carrying the fired events, the count and the armed slots.
`default_nettype none

interface rpce_evt_if;
  logic                             valid;
  logic                             ready;
  logic [rpce_pkg::MASK_W-1:0]      periodic_fire;
  logic [rpce_pkg::MASK_W-1:0]      compare_fire;
  logic [rpce_pkg::COUNT_W-1:0]     count_now;
  logic [rpce_pkg::MASK_W-1:0]      armed_mask;

  modport source (output valid, periodic_fire, compare_fire, count_now, armed_mask,
                  input ready);
  modport sink   (input valid, periodic_fire, compare_fire, count_now, armed_mask,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/rtc_periodic_and_compare_events_unit.sv
// Top level of the 128 Hz real-time counter with periodic and compare events.
`default_nettype none

// Usage: requests arrive on cmd. A tick request (kind 0) advances the 32-bit
// count; arm (kind 1) loads compare_value into a compare slot and arms it;
// disarm (kind 2) clears the slot's armed bit. Any other kind, or a slot index
// at or above COMPARE_SLOTS, changes nothing but still yields a result.
// Every request produces exactly one result on evt: the periodic rates and
// compare slots that fired, the count after the request and the armed slots.
// A compare slot fires on the tick after the count reached its target; the
// slots that fire are disarmed and the nearest armed target ahead is chosen.
// Timing: a request taken on cmd sits in the input register, where all of its
// work is done, and its result is registered into the result register and
// shown on evt. The block takes one request per cycle as long as evt is
// taken; a single pass through the state update and the slot comparator
// tree sets this rate. When evt stalls, the result register holds and the
// input register keeps one more request, after which cmd.ready falls. Reset
// (rst, synchronous) clears the count, the scheduled target, all compare
// slots, the periodic enable register and both valid flags.
// The periodic enable register sits at APB byte address 0 and reads back.
module rtc_periodic_and_compare_events_unit #(
  parameter int COMPARE_SLOTS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  rpce_cmd_if.sink                          cmd,
  rpce_evt_if.source                        evt,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rpce_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [rpce_pkg::CFG_DW-1:0]  pwdata,
  output logic      [rpce_pkg::CFG_DW-1:0]  prdata,
  output logic                              pready
);

  localparam int W  = rpce_pkg::COUNT_W;
  localparam int MW = rpce_pkg::MASK_W;

  // Configuration register. The user must write it only while the block is idle; the block does not enforce this.
  logic [MW-1:0] periodic_enable;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      periodic_enable <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == rpce_pkg::ADDR_PERIODIC_ENABLE)) begin
      periodic_enable <= pwdata[MW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == rpce_pkg::ADDR_PERIODIC_ENABLE) begin
      prdata = {{(rpce_pkg::CFG_DW-MW){1'b0}}, periodic_enable};
    end
  end

  // Input register.
  logic                         s1_valid;
  logic [rpce_pkg::KIND_W-1:0]  s1_kind;
  logic [rpce_pkg::SLOT_W-1:0]  s1_slot;
  logic [W-1:0]                 s1_value;
  logic                         s1_adv;
  logic                         out_valid;

  assign s1_adv    = s1_valid && (!out_valid || evt.ready);
  assign cmd.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_kind  <= cmd.kind;
      s1_slot  <= cmd.slot;
      s1_value <= cmd.compare_value;
    end
  end

  // Counter and compare state.
  logic [W-1:0]         count;
  logic [W-1:0]         sched;
  logic [COMPARE_SLOTS-1:0] armed;
  logic [W-1:0]         target [COMPARE_SLOTS];

  logic [W-1:0]         count_next;
  logic [W-1:0]         sched_next;
  logic [COMPARE_SLOTS-1:0] armed_next;
  logic [W-1:0]         target_next [COMPARE_SLOTS];
  logic [COMPARE_SLOTS-1:0] fire;
  logic                 is_tick;
  logic                 hit;
  logic                 slot_ok;
  logic                 do_pick;
  logic                 found;
  logic [W-1:0]         chosen;
  logic [MW-1:0]        pfire;

  // The lowest set bit of the low count bits selects the rate; all zero selects
  // the 128 Hz slot, which also fires alongside every slower rate.
  function automatic logic [MW-1:0] periodic_for(logic [rpce_pkg::SUB_BITS-1:0] sub,
                                                 logic [MW-1:0] mask);
    logic [2:0]    rate;
    logic [MW-1:0] fired;
    rate = '0;
    for (int i = rpce_pkg::SUB_BITS - 1; i >= 0; i--) begin
      if (sub[i]) begin
        rate = 3'(i + 1);
      end
    end
    fired = mask & (MW'(1) << rate);
    if (rate != '0) begin
      fired[0] = mask[0];
    end
    return fired;
  endfunction

  always_comb begin
    is_tick    = (s1_kind == rpce_pkg::KIND_TICK);
    slot_ok    = (int'(s1_slot) < COMPARE_SLOTS) &&
                 ((s1_kind == rpce_pkg::KIND_ARM) || (s1_kind == rpce_pkg::KIND_DISARM));
    count_next = is_tick ? (count + W'(1)) : count;
    // The scheduled event is due on the tick after the count reached it.
    hit        = is_tick && (count_next == (sched + W'(1)));
    for (int i = 0; i < COMPARE_SLOTS; i++) begin
      fire[i]        = hit && armed[i] && (target[i] == sched);
      armed_next[i]  = armed[i] && !fire[i];
      target_next[i] = target[i];
      if (slot_ok && (int'(s1_slot) == i)) begin
        armed_next[i] = (s1_kind == rpce_pkg::KIND_ARM);
        if (s1_kind == rpce_pkg::KIND_ARM) begin
          target_next[i] = s1_value;
        end
      end
    end
    // A target that equals the count is still pending and is left alone.
    do_pick    = (hit || slot_ok) && (count_next != sched);
    sched_next = sched;
    if (do_pick) begin
      sched_next = found ? chosen : (count_next - W'(1));
    end
    pfire = is_tick ? periodic_for(count_next[rpce_pkg::SUB_BITS-1:0], periodic_enable)
                    : '0;
  end

  rpce_sched #(
    .SLOTS (COMPARE_SLOTS)
  ) u_sched (
    .next_count (count_next + W'(1)),
    .armed      (armed_next),
    .target     (target_next),
    .found      (found),
    .chosen     (chosen)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sched <= '0;
      armed <= '0;
    end else if (s1_adv) begin
      count <= count_next;
      sched <= sched_next;
      armed <= armed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= '{default: '0};
    end else if (s1_adv) begin
      target <= target_next;
    end
  end

  // Only the first eight slots are visible on the result fields.
  logic [MW-1:0] armed_lo;
  logic [MW-1:0] fire_lo;

  always_comb begin
    armed_lo = '0;
    fire_lo  = '0;
    for (int i = 0; i < MW; i++) begin
      if (i < COMPARE_SLOTS) begin
        armed_lo[i] = armed_next[i];
        fire_lo[i]  = fire[i];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (evt.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      evt.periodic_fire <= pfire;
      evt.compare_fire  <= fire_lo;
      evt.count_now     <= count_next;
      evt.armed_mask    <= armed_lo;
    end
  end

  assign evt.valid = out_valid;

  // A slot that fires is no longer armed in the same result.
  a_fired_disarmed: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> ((evt.compare_fire & evt.armed_mask) == '0))
    else $error("fired compare slot still armed");

  // Non-tick requests (arm, disarm and any other kind) never fire anything.
  a_quiet_non_tick: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && !is_tick) |=> ((evt.periodic_fire == '0) && (evt.compare_fire == '0)))
    else $error("event fired on a non-tick request");

  // The count moves by one on a tick and holds otherwise.
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> (count == ($past(is_tick) ? W'($past(count) + W'(1)) : $past(count))))
    else $error("count stepped wrongly");

  // Only slots that were armed before the request can fire.
  a_fire_was_armed: assert property (@(posedge clk) disable iff (rst)
    s1_adv |-> ((fire & ~armed) == '0))
    else $error("unarmed compare slot fired");

endmodule

`default_nettype wire

// File: rtl/core/rpce_sched.sv
// Comparator tree that picks the armed compare slot nearest ahead of the next count.
`default_nettype none

module rpce_sched #(
  parameter int SLOTS = 8
) (
  input  wire logic [rpce_pkg::COUNT_W-1:0] next_count,
  input  wire logic [SLOTS-1:0]             armed,
  input  wire logic [rpce_pkg::COUNT_W-1:0] target [SLOTS],
  output logic                              found,
  output logic [rpce_pkg::COUNT_W-1:0]      chosen
);

  localparam int LEVELS = (SLOTS > 1) ? $clog2(SLOTS) : 0;
  localparam int NP     = 1 << LEVELS;
  localparam int NODES  = 2 * NP - 1;

  typedef struct packed {
    logic                         valid;
    logic [rpce_pkg::COUNT_W-1:0] ahead;
    logic [rpce_pkg::COUNT_W-1:0] tgt;
  } cand_t;

  // Ties go to the higher slot, so the right child wins when distances are equal.
  function automatic cand_t pick_later(cand_t lo, cand_t hi);
    if (hi.valid && (!lo.valid || (hi.ahead <= lo.ahead))) begin
      return hi;
    end
    return lo;
  endfunction

  cand_t node [NODES];

  for (genvar g = 0; g < NP; g++) begin : g_leaf
    if (g < SLOTS) begin : g_used
      assign node[NP-1+g] = '{valid: armed[g], ahead: target[g] - next_count, tgt: target[g]};
    end else begin : g_pad
      assign node[NP-1+g] = '0;
    end
  end

  for (genvar k = 0; k < NP - 1; k++) begin : g_node
    assign node[k] = pick_later(node[2*k+1], node[2*k+2]);
  end

  assign found  = node[0].valid;
  assign chosen = node[0].tgt;

endmodule

`default_nettype wire
